>>> rtl/bohist_pkg.sv
// ----------------------------------------------------------------------------
// bohist_pkg: shared types and constants of the orbit histogram core
// Holds the sequencer states, the command and multiplier operation codes,
// the register indexes and the fixed-point constants that the modules share.
// ----------------------------------------------------------------------------
package bohist_pkg;

    localparam int GRID_WIDTH_DEF  = 256;
    localparam int GRID_HEIGHT_DEF = 256;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int Z_BITS   = 40;
    localparam int FRAC     = 24;
    localparam int STEP_BITS = 20;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [1:0] REG_TIER_ONE = 2'd0;
    localparam logic [1:0] REG_TIER_TWO = 2'd1;
    localparam logic [1:0] REG_ITER_LIM = 2'd2;

    // 10000^2 in Q40.24, 1.5 in Q16.24 and 3.0 in unsigned Q3.24
    localparam logic signed [63:0] ESCAPE_SQ = 64'sd1677721600000000;
    localparam logic signed [Z_BITS-1:0] HALF_SPAN = 40'sd25165824;
    localparam logic [26:0] FULL_SPAN = 27'd50331648;

    // Operation codes for the shared multiplier.
    typedef enum logic [2:0] {
        MUL_XX,
        MUL_YY,
        MUL_XY,
        MUL_NXX,
        MUL_NYY,
        MUL_COL,
        MUL_ROW
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MUL,
        ST_UPDATE,
        ST_CHECK,
        ST_PIX,
        ST_RD,
        ST_WR,
        ST_READ,
        ST_OUT
    } state_t;

endpackage

>>> rtl/bohist_mul.sv
// ----------------------------------------------------------------------------
// bohist_mul: shared iterative fixed-point multiplier
// Multiplies two signed 40-bit values, 20 bits of the second operand per
// cycle, and returns floor(a*b / 2^24).
// ----------------------------------------------------------------------------
module bohist_mul
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [39:0]  a,
    input  logic signed [39:0]  b,
    output logic                done,
    output logic signed [63:0]  product
);

    logic [39:0] ma_reg;
    logic [39:0] mb_reg;
    logic        neg_reg;
    logic [79:0] acc_reg;
    logic [1:0]  phase_reg;
    logic        busy_reg;
    logic [59:0] part;
    logic [79:0] shifted;

    always_comb
    begin
        if (phase_reg == 2'd0)
            part = ma_reg * mb_reg[19:0];
        else
            part = ma_reg * mb_reg[39:20];
        shifted = (phase_reg == 2'd0) ? {20'd0, part} : {part, 20'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                if (phase_reg == 2'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                phase_reg <= phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a[39] ? 40'(-a) : 40'(a);
            mb_reg  <= b[39] ? 40'(-b) : 40'(b);
            neg_reg <= a[39] ^ b[39];
            acc_reg <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_reg + shifted;
    end

    logic [63:0] hi;
    assign hi = 64'(acc_reg >> bohist_pkg::FRAC);
    assign product = neg_reg
        ? -$signed(hi + 64'((acc_reg[bohist_pkg::FRAC-1:0] != '0) ? 1 : 0))
        : $signed(hi);

endmodule

>>> rtl/bohist_store.sv
// ----------------------------------------------------------------------------
// bohist_store: hit counter memory
// One write port and one registered read port over all pixel counters.
// ----------------------------------------------------------------------------
module bohist_store
#(
    parameter int DEPTH = 3 * bohist_pkg::GRID_WIDTH_DEF * bohist_pkg::GRID_HEIGHT_DEF,
    parameter int COUNT_BITS = bohist_pkg::COUNT_BITS_DEF,
    parameter int ADDR_BITS = $clog2(DEPTH)
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_BITS-1:0]  wr_addr,
    input  logic [COUNT_BITS-1:0] wr_data,
    input  logic [ADDR_BITS-1:0]  rd_addr,
    output logic [COUNT_BITS-1:0] rd_data
);

    logic [COUNT_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/buddhabrot_orbit_histogram_core.sv
// ----------------------------------------------------------------------------
// buddhabrot_orbit_histogram_core: orbit histogram renderer core
// Iterates sample points on a shared multiplier and counts orbit visits.
// ----------------------------------------------------------------------------
// A request on the input channel (in_valid/in_stall) carries a command. A
// sample request iterates z = z*z + c on one shared multiplier, five
// products per iteration, with an update step after the third and an escape
// test after the fifth. An escaping orbit is replayed from c, with a pixel
// step per point; a point inside the square adds two products and a counter
// read-modify-write per counted channel. A read request captures the
// addressed counter in a read state, then goes to the output state. The
// block takes one request at a time and stalls its input until the result
// is taken on the output channel (out_valid/out_stall); the result register
// holds while the output stalls. After reset a clearing pass writes every
// counter to zero, one per cycle, while no request is accepted.
// Configuration writes are taken at any time through cfg_write.
// ----------------------------------------------------------------------------
module buddhabrot_orbit_histogram_core
#(
    parameter int GRID_WIDTH  = bohist_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = bohist_pkg::GRID_HEIGHT_DEF,
    parameter int COUNT_BITS  = bohist_pkg::COUNT_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic signed [31:0] c_real,
    input  logic signed [31:0] c_imag,
    input  logic [15:0]        pixel_index,
    input  logic [1:0]         color_channel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         escape_class,
    output logic [19:0]        escape_step,
    output logic [31:0]        count_value,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [19:0]        cfg_data
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int DEPTH = 3 * CELLS;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int COL_BITS = $clog2(GRID_WIDTH);
    localparam int ROW_BITS = $clog2(GRID_HEIGHT);
    localparam logic [COUNT_BITS-1:0] TOP = '1;

    bohist_pkg::state_t state_reg, state_next;

    logic [19:0] tier1_reg, tier2_reg, limit_reg;
    logic signed [39:0] cr_reg, ci_reg, x_reg, y_reg;
    logic signed [63:0] xx_reg, yy_reg, xy_reg;
    logic [19:0] n_reg, esc_reg;
    logic        replay_reg;
    logic [1:0]  cls_reg;
    logic [2:0]  op_reg;
    logic [ADDR_BITS-1:0] clr_reg, addr_reg;
    logic [1:0]  ch_reg;
    logic [COL_BITS-1:0] col_reg;

    logic        mul_start, mul_done;
    logic signed [39:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic        mul_wait_reg;
    logic        mul_kick;
    logic        mem_we;
    logic [ADDR_BITS-1:0] mem_wa, mem_ra;
    logic [COUNT_BITS-1:0] mem_wd, mem_rd;

    logic signed [63:0] nx_full, ny_full;
    logic signed [39:0] nx_sat, ny_sat;
    logic in_box, last_op, escaped;
    logic [26:0] x_off, y_off;
    logic [15:0] coord_v;
    logic [32:0] coord_m;
    logic [15:0] coord_q;

    function automatic logic signed [39:0] clamp40(input logic signed [63:0] v);
        if (v > 64'sd549755813887)
            return 40'sh7FFFFFFFFF;
        else if (v < -64'sd549755813888)
            return 40'sh8000000000;
        else
            return v[39:0];
    endfunction

    assign nx_full = xx_reg - yy_reg + 64'(cr_reg);
    assign ny_full = (xy_reg <<< 1) + 64'(ci_reg);
    assign nx_sat = clamp40(nx_full);
    assign ny_sat = clamp40(ny_full);
    assign escaped = (xx_reg + yy_reg) > bohist_pkg::ESCAPE_SQ;
    assign in_box = (x_reg > -bohist_pkg::HALF_SPAN) && (x_reg < bohist_pkg::HALF_SPAN)
                 && (y_reg > -bohist_pkg::HALF_SPAN) && (y_reg < bohist_pkg::HALF_SPAN);
    assign x_off = 27'(x_reg + bohist_pkg::HALF_SPAN);
    assign y_off = 27'(y_reg + bohist_pkg::HALF_SPAN);

    // Pixel coordinates: offset * size on the shared multiplier, then the
    // integer part is divided by three through a reciprocal multiplication.
    always_comb
    begin
        mul_a = x_reg;
        mul_b = x_reg;
        unique case (op_reg)
            bohist_pkg::MUL_XX, bohist_pkg::MUL_NXX:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            bohist_pkg::MUL_YY, bohist_pkg::MUL_NYY:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            bohist_pkg::MUL_XY:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
            bohist_pkg::MUL_COL:
            begin
                mul_a = 40'(x_off);
                mul_b = 40'(GRID_WIDTH) <<< bohist_pkg::FRAC;
            end
            bohist_pkg::MUL_ROW:
            begin
                mul_a = 40'(y_off);
                mul_b = 40'(GRID_HEIGHT) <<< bohist_pkg::FRAC;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
        endcase
    end

    bohist_mul u_mul
    (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .product(mul_p)
    );

    bohist_store #(.DEPTH(DEPTH), .COUNT_BITS(COUNT_BITS), .ADDR_BITS(ADDR_BITS)) u_store
    (
        .clk(clk), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
        .rd_addr(mem_ra), .rd_data(mem_rd)
    );

    // The integer part stays below three times the grid size, well under
    // 2^17, where multiplying by 43691 / 2^17 gives the exact floor of v / 3.
    assign coord_v = 16'(mul_p >>> bohist_pkg::FRAC);
    assign coord_m = 33'(coord_v) * 33'(17'd43691);
    assign coord_q = 16'(coord_m >> 17);

    assign last_op = (op_reg == 3'(bohist_pkg::MUL_NYY));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bohist_pkg::ST_CLEAR:
                if (clr_reg == ADDR_BITS'(DEPTH - 1))
                    state_next = bohist_pkg::ST_IDLE;
            bohist_pkg::ST_IDLE:
                if (in_valid)
                begin
                    if (command == bohist_pkg::CMD_READ)
                        state_next = bohist_pkg::ST_READ;
                    else if (limit_reg == 20'd0)
                        state_next = bohist_pkg::ST_OUT;
                    else
                        state_next = bohist_pkg::ST_MUL;
                end
            bohist_pkg::ST_MUL:
                if (mul_done)
                begin
                    if (op_reg == 3'(bohist_pkg::MUL_XY))
                        state_next = bohist_pkg::ST_UPDATE;
                    else if (last_op)
                        state_next = bohist_pkg::ST_CHECK;
                    else if (op_reg == 3'(bohist_pkg::MUL_ROW))
                        state_next = bohist_pkg::ST_RD;
                end
            bohist_pkg::ST_UPDATE:
                state_next = bohist_pkg::ST_MUL;
            bohist_pkg::ST_CHECK:
                if (!replay_reg)
                begin
                    if (escaped || n_reg + 20'd1 >= limit_reg)
                        state_next = escaped ? bohist_pkg::ST_MUL : bohist_pkg::ST_OUT;
                    else
                        state_next = bohist_pkg::ST_MUL;
                end
                else
                    state_next = in_box ? bohist_pkg::ST_MUL : bohist_pkg::ST_PIX;
            bohist_pkg::ST_RD:
                state_next = bohist_pkg::ST_WR;
            bohist_pkg::ST_WR:
                if (ch_reg == 2'd2 || (ch_reg == 2'd1 && cls_reg == 2'd2)
                    || (ch_reg == 2'd0 && cls_reg == 2'd3))
                    state_next = bohist_pkg::ST_PIX;
                else
                    state_next = bohist_pkg::ST_RD;
            bohist_pkg::ST_PIX:
                state_next = (n_reg == esc_reg) ? bohist_pkg::ST_OUT : bohist_pkg::ST_MUL;
            bohist_pkg::ST_READ:
                state_next = bohist_pkg::ST_OUT;
            bohist_pkg::ST_OUT:
                if (!out_stall)
                    state_next = bohist_pkg::ST_IDLE;
            default:
                state_next = bohist_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != bohist_pkg::ST_IDLE);
        out_valid = (state_reg == bohist_pkg::ST_OUT);
        mul_start = mul_kick;
        mem_we    = 1'b0;
        mem_wa    = addr_reg;
        mem_wd    = (mem_rd == TOP) ? mem_rd : mem_rd + COUNT_BITS'(1);
        mem_ra    = addr_reg;
        unique case (state_reg)
            bohist_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = '0;
            end
            bohist_pkg::ST_UPDATE, bohist_pkg::ST_PIX:
                mul_start = 1'b0;
            bohist_pkg::ST_WR:
                mem_we = 1'b1;
            // The counter is read at the accepting edge, while the request holds.
            bohist_pkg::ST_IDLE:
                mem_ra = ADDR_BITS'(32'(pixel_index) * 3 + 32'(color_channel));
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bohist_pkg::ST_CLEAR;
            clr_reg   <= '0;
            tier1_reg <= 20'd1500;
            tier2_reg <= 20'd15000;
            limit_reg <= 20'd150000;
            op_reg    <= 3'(bohist_pkg::MUL_XX);
            n_reg     <= '0;
            replay_reg <= 1'b0;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == bohist_pkg::ST_CLEAR)
                clr_reg <= clr_reg + ADDR_BITS'(1);
            if (cfg_write)
            begin
                unique case (cfg_index)
                    bohist_pkg::REG_TIER_ONE: tier1_reg <= cfg_data;
                    bohist_pkg::REG_TIER_TWO: tier2_reg <= cfg_data;
                    bohist_pkg::REG_ITER_LIM: limit_reg <= cfg_data;
                    default: tier1_reg <= tier1_reg;
                endcase
            end
            unique case (state_reg)
                bohist_pkg::ST_IDLE:
                begin
                    op_reg <= 3'(bohist_pkg::MUL_XX);
                    n_reg <= '0;
                    replay_reg <= 1'b0;
                    ch_reg <= (command == bohist_pkg::CMD_READ
                               && (32'(pixel_index) >= CELLS || color_channel == 2'd3))
                              ? 2'd3 : 2'd0;
                end
                bohist_pkg::ST_MUL:
                    if (mul_done && op_reg != 3'(bohist_pkg::MUL_ROW) && !last_op
                        && op_reg != 3'(bohist_pkg::MUL_XY))
                        op_reg <= op_reg + 3'd1;
                bohist_pkg::ST_UPDATE:
                    op_reg <= 3'(bohist_pkg::MUL_NXX);
                bohist_pkg::ST_CHECK:
                begin
                    op_reg <= (replay_reg && in_box) ? 3'(bohist_pkg::MUL_COL)
                                                     : 3'(bohist_pkg::MUL_XX);
                    if (!replay_reg)
                    begin
                        if (escaped)
                        begin
                            replay_reg <= 1'b1;
                            n_reg <= '0;
                        end
                        else
                            n_reg <= n_reg + 20'd1;
                    end
                    else if (in_box)
                        ch_reg <= '0;
                end
                bohist_pkg::ST_WR:
                    ch_reg <= ch_reg + 2'd1;
                bohist_pkg::ST_PIX:
                begin
                    n_reg <= n_reg + 20'd1;
                    op_reg <= 3'(bohist_pkg::MUL_XX);
                end
                default:
                    op_reg <= op_reg;
            endcase
        end
    end

    // Start the multiplier on the first cycle of each operation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_wait_reg <= 1'b0;
        else if (state_reg == bohist_pkg::ST_MUL)
            mul_wait_reg <= !mul_done && (mul_wait_reg || 1'b1);
        else
            mul_wait_reg <= 1'b0;
    end
    assign mul_kick = (state_reg == bohist_pkg::ST_MUL) && !mul_wait_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == bohist_pkg::ST_IDLE && in_valid)
        begin
            cr_reg <= 40'(c_real >>> 4);
            ci_reg <= 40'(c_imag >>> 4);
            x_reg  <= 40'(c_real >>> 4);
            y_reg  <= 40'(c_imag >>> 4);
            escape_class <= 2'd0;
            escape_step  <= 20'd0;
            count_value  <= 32'd0;
        end
        if (state_reg == bohist_pkg::ST_MUL && mul_done)
        begin
            unique case (op_reg)
                bohist_pkg::MUL_XX, bohist_pkg::MUL_NXX: xx_reg <= mul_p;
                bohist_pkg::MUL_YY, bohist_pkg::MUL_NYY: yy_reg <= mul_p;
                bohist_pkg::MUL_XY: xy_reg <= mul_p;
                bohist_pkg::MUL_COL: col_reg <= COL_BITS'(coord_q);
                bohist_pkg::MUL_ROW:
                    addr_reg <= ADDR_BITS'((32'(ROW_BITS'(coord_q)) * GRID_WIDTH
                                + 32'(col_reg)) * 3);
                default: xx_reg <= xx_reg;
            endcase
        end
        if (state_reg == bohist_pkg::ST_UPDATE)
        begin
            x_reg <= nx_sat;
            y_reg <= ny_sat;
        end
        if (state_reg == bohist_pkg::ST_CHECK && !replay_reg && escaped)
        begin
            esc_reg <= n_reg;
            x_reg <= cr_reg;
            y_reg <= ci_reg;
            escape_step <= n_reg + 20'd1;
            escape_class <= (n_reg < tier1_reg) ? 2'd1 : (n_reg < tier2_reg) ? 2'd2 : 2'd3;
            cls_reg <= (n_reg < tier1_reg) ? 2'd1 : (n_reg < tier2_reg) ? 2'd2 : 2'd3;
        end
        if (state_reg == bohist_pkg::ST_WR)
            addr_reg <= addr_reg + ADDR_BITS'(1);
        if (state_reg == bohist_pkg::ST_READ)
            count_value <= (ch_reg == 2'd3) ? 32'd0 : 32'(mem_rd);
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(count_value))
        else $error("result changed under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bohist_pkg::ST_CLEAR) |-> in_stall)
        else $error("request accepted during clear");
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !out_valid)
        else $error("counter write while result pending");

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for buddhabrot_orbit_histogram_core
// Drives sample and read requests with random idling on both channels, runs
// a fixed-point orbit predictor with its own counter store and compares every
// result field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_NONE  = 2'd3;
    localparam longint Z_HI = 64'sd549755813887;
    localparam longint Z_LO = -64'sd549755813888;
    localparam longint ESC_SQ = 64'sd1677721600000000;
    localparam longint HALF = 64'sd25165824;
    localparam longint SPAN = 64'sd50331648;

    typedef struct {
        logic [1:0]  cls;
        logic [19:0] step;
        logic [31:0] cnt;
    } orbit_result_t;

    typedef struct {
        logic        cmd;
        logic [31:0] cr;
        logic [31:0] ci;
        logic [15:0] pix;
        logic [1:0]  ch;
        bit          typed;
        logic [31:0] cnt;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic command = bohist_pkg::CMD_SAMPLE;
    logic signed [31:0] c_real = '0;
    logic signed [31:0] c_imag = '0;
    logic [15:0] pixel_index = '0;
    logic [1:0] color_channel = CH_RED;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] escape_class;
    logic [19:0] escape_step;
    logic [31:0] count_value;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = bohist_pkg::REG_TIER_ONE;
    logic [19:0] cfg_data = '0;

    // Predictor state: counters, registers, and pixels known to hold hits.
    int unsigned hit_store[int];
    int visited_pixels[$];
    int unsigned tier_one = 1500, tier_two = 15000, iter_cap = 150000;
    orbit_result_t pending_results[$];
    int mismatches = 0, samples_run = 0, reads_run = 0, escapes_seen = 0;
    bit quiet = 1'b0;
    int hold_left = 0;
    int stall_left = 0;

    buddhabrot_orbit_histogram_core i_dut (.*);

    always #10 clk = ~clk;

    function automatic longint fx_product(longint a, longint b);
        logic signed [95:0] wa, wb, p;
        wa = a;
        wb = b;
        p = (wa * wb) >>> 24;
        return longint'(p);
    endfunction

    function automatic longint clip40(longint v);
        return v > Z_HI ? Z_HI : (v < Z_LO ? Z_LO : v);
    endfunction

    function automatic bit orbit_step(ref longint x, ref longint y, input longint cr,
                                      input longint ci);
        longint xx, yy, xy;
        xx = fx_product(x, x);
        yy = fx_product(y, y);
        xy = fx_product(x, y);
        x = clip40(xx - yy + cr);
        y = clip40(2 * xy + ci);
        return fx_product(x, x) + fx_product(y, y) > ESC_SQ;
    endfunction

    function automatic void bump_counter(int slot);
        if (!hit_store.exists(slot))
            hit_store[slot] = 0;
        if (hit_store[slot] != 32'hFFFF_FFFF)
            hit_store[slot]++;
    endfunction

    function automatic orbit_result_t predict_request(stim_row_t r);
        orbit_result_t res;
        longint cr, ci, x, y, col, row;
        int unsigned n, esc_n;
        bit escaped;
        int slot;
        res.cls = 2'd0;
        res.step = '0;
        res.cnt = '0;
        if (r.cmd == bohist_pkg::CMD_READ) begin
            slot = int'(r.pix) * 3 + int'(r.ch);
            if (r.ch != CH_NONE && hit_store.exists(slot))
                res.cnt = hit_store[slot];
            return res;
        end
        cr = longint'($signed(r.cr)) >>> 4;
        ci = longint'($signed(r.ci)) >>> 4;
        x = cr;
        y = ci;
        escaped = 1'b0;
        esc_n = 0;
        for (n = 0; n < iter_cap; n++) begin
            if (orbit_step(x, y, cr, ci)) begin
                escaped = 1'b1;
                esc_n = n;
                break;
            end
        end
        if (!escaped)
            return res;
        res.cls = esc_n < tier_one ? 2'd1 : (esc_n < tier_two ? 2'd2 : 2'd3);
        res.step = 20'(esc_n + 1);
        x = cr;
        y = ci;
        for (n = 0; n <= esc_n; n++) begin
            void'(orbit_step(x, y, cr, ci));
            if (x > -HALF && x < HALF && y > -HALF && y < HALF) begin
                col = ((x + HALF) * 256) / SPAN;
                row = ((y + HALF) * 256) / SPAN;
                slot = int'(row * 256 + col);
                bump_counter(slot * 3);
                if (res.cls <= 2)
                    bump_counter(slot * 3 + 1);
                if (res.cls == 1)
                    bump_counter(slot * 3 + 2);
                visited_pixels.push_back(slot);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // One request on the input channel; the prediction is queued on acceptance.
    task automatic send_request(stim_row_t r);
        orbit_result_t res;
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        command = r.cmd;
        c_real = r.cr;
        c_imag = r.ci;
        pixel_index = r.pix;
        color_channel = r.ch;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        res = predict_request(r);
        if (r.typed)
            res.cnt = r.cnt;
        pending_results.push_back(res);
        if (r.cmd == bohist_pkg::CMD_READ)
            reads_run++;
        else
            samples_run++;
        if (res.cls != 0)
            escapes_seen++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        drain();
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val[19:0];
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            bohist_pkg::REG_TIER_ONE: tier_one = val;
            bohist_pkg::REG_TIER_TWO: tier_two = val;
            default:                  iter_cap = val;
        endcase
    endtask

    task automatic set_regs(int unsigned t1, int unsigned t2, int unsigned lim);
        write_reg(bohist_pkg::REG_TIER_ONE, t1);
        write_reg(bohist_pkg::REG_TIER_TWO, t2);
        write_reg(bohist_pkg::REG_ITER_LIM, lim);
    endtask

    function automatic stim_row_t sample_row(logic [31:0] cr, logic [31:0] ci);
        stim_row_t r;
        r = '{bohist_pkg::CMD_SAMPLE, cr, ci, 16'($urandom), 2'($urandom), 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t read_row(int pix, logic [1:0] ch);
        stim_row_t r;
        r = '{bohist_pkg::CMD_READ, $urandom, $urandom, 16'(pix), ch, 1'b0, '0};
        return r;
    endfunction

    // Coordinate in [-2.0, 2.0), where most orbits live.
    function automatic logic [31:0] near_coord();
        return 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
    endfunction

    // Point with magnitude of at least 4.0, which always escapes in a few steps.
    function automatic logic [31:0] far_coord();
        logic [31:0] v;
        v = 32'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    function automatic stim_row_t random_row();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return sample_row(near_coord(), near_coord());
        if (pick == 5)
            return sample_row($urandom, $urandom);
        if (pick < 9 && visited_pixels.size() != 0)
            return read_row(visited_pixels[$urandom_range(0, visited_pixels.size() - 1)],
                            2'($urandom_range(0, 2)));
        return read_row($urandom_range(0, 65535), 2'($urandom));
    endfunction

    // Receiver: checks at the rising edge, chooses its stall at the falling edge.
    initial begin
        orbit_result_t want;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result", 32'd1, 32'd0);
                else begin
                    want = pending_results.pop_front();
                    if (escape_class !== want.cls)
                        report_mismatch("escape_class", 32'(escape_class), 32'(want.cls));
                    if (escape_step !== want.step)
                        report_mismatch("escape_step", 32'(escape_step), 32'(want.step));
                    if (count_value !== want.cnt)
                        report_mismatch("count_value", count_value, want.cnt);
                end
            end
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (!quiet && !out_stall && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial begin
        #100ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        stim_row_t opening[$];
        int k;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        set_regs(1, 4, 32);

        // Fresh-store reads, bad channel, fixed and random samples, then reads.
        opening.push_back('{bohist_pkg::CMD_READ, '0, '0, 16'd0, CH_RED, 1'b1, '0});
        opening.push_back('{bohist_pkg::CMD_READ, '1, '1, 16'hFFFF, CH_BLUE, 1'b1, '0});
        opening.push_back('{bohist_pkg::CMD_READ, '0, '0, 16'd100, CH_NONE, 1'b1, '0});
        opening.push_back('{bohist_pkg::CMD_READ, '0, '0, 16'd32896, CH_GREEN, 1'b1, '0});
        opening.push_back(sample_row(32'h0000_0000, 32'h0000_0000));
        opening.push_back(sample_row(32'hE000_0000, 32'h0000_0000));
        opening.push_back(sample_row(32'h1000_0000, 32'h0000_0000));
        opening.push_back(sample_row(32'h0000_0000, 32'h1000_0000));
        opening.push_back(sample_row(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        opening.push_back(sample_row(32'h8000_0000, 32'h8000_0000));
        opening.push_back(sample_row(32'h8000_0000, 32'h7FFF_FFFF));
        opening.push_back(sample_row(32'hF400_0000, 32'h0199_999A));
        opening.push_back(sample_row(32'h04CC_CCCD, 32'h0800_0000));
        opening.push_back(sample_row(32'hE800_0000, 32'h0000_0000));
        opening.push_back(sample_row(32'h0666_6666, 32'h04CC_CCCD));
        opening.push_back(sample_row(32'h1800_0000, 32'hE800_0000));
        foreach (opening[i])
            send_request(opening[i]);
        for (k = 0; k < 6; k++)
            send_request(random_row());
        for (k = 0; k < 3; k++)
            send_request(read_row(k < visited_pixels.size() ? visited_pixels[k] : k,
                                  2'(k)));

        // Register extremes: tiers out of order, a single iteration, none at all,
        // and the widest limit with points that escape quickly.
        set_regs(1048575, 1, 1);
        for (k = 0; k < 4; k++)
            send_request(sample_row(far_coord(), far_coord()));
        write_reg(bohist_pkg::REG_ITER_LIM, 0);
        for (k = 0; k < 3; k++)
            send_request(sample_row(far_coord(), near_coord()));
        set_regs(2, 3, 1048575);
        for (k = 0; k < 6; k++)
            send_request(sample_row(far_coord(), far_coord()));

        // Random phases with fresh register settings; the last runs without idling.
        for (int phase = 0; phase < 4; phase++) begin
            set_regs($urandom_range(1, 20), $urandom_range(1, 40), $urandom_range(8, 64));
            if (phase == 3)
                quiet = 1'b1;
            for (k = 0; k < 18; k++) begin
                if (phase == 1 && k == 5)
                    hold_left = 300;
                send_request(random_row());
            end
        end
        drain();
        $display("ran %0d sample and %0d read requests, %0d orbits escaped",
                 samples_run, reads_run, escapes_seen);
        $display("register extremes, tier order swaps and output hold-offs covered");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

>>> buddhabrot_orbit_histogram_core.f
rtl/bohist_pkg.sv
rtl/bohist_mul.sv
rtl/bohist_store.sv
rtl/buddhabrot_orbit_histogram_core.sv
verif/tb.sv
